### rtl/box_blur_3x3_rgb_core_macros.svh
// Assertion helpers for the checker file.
`ifndef BOX_BLUR_3X3_RGB_CORE_MACROS_SVH
`define BOX_BLUR_3X3_RGB_CORE_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define BB3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define BB3_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bb3_pkg.sv
`timescale 1ns / 1ps
package bb3_pkg;

    localparam int MAX_SIZE_DEF = 1024;
    localparam int SIZE_W       = 11;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 11'd32;
    localparam int POS_W        = 10;
    localparam int CH_W         = 16;
    localparam int SUM_W        = 20;
    localparam int RECIP_W      = 20;
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam int DIV_SHIFT    = 21;

    // Reciprocals scaled by 2**DIV_SHIFT, exact for sums below 2**19 (RECIP9, RECIP4: below 2**20)
    localparam logic [RECIP_W-1:0] RECIP9 = 20'd233017;
    localparam logic [RECIP_W-1:0] RECIP6 = 20'd349526;
    localparam logic [RECIP_W-1:0] RECIP4 = 20'd524288;

    // Result kinds of one pixel, in emission order
    localparam int KIND_A = 0;  // (r-1, c-1)
    localparam int KIND_B = 1;  // (r-1, c) at right edge
    localparam int KIND_C = 2;  // (r, c-1) on last row
    localparam int KIND_D = 3;  // (r, c) last pixel
    localparam int KIND_N = 4;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } t_div;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_px;

    typedef struct packed {
        t_px older;
        t_px newer;
    } t_line;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic             run_last;
    } t_out;

endpackage

### rtl/bb3_ram.sv
`timescale 1ns / 1ps
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read port that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/box_blur_3x3_rgb_core.sv
`timescale 1ns / 1ps
// 3x3 box mean over a square RGB image streamed in raster order.
// Input channel: i_valid / o_stall with i_data, one pixel per word.
// Output channel: o_valid / i_stall with o_data: row, column, three
// channel means and run_last, set on the last word caused by a pixel.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes the
// image size; write it only while the block is idle. It restarts the
// image at row 0, column 0. Sizes are clamped to 2..MAX_SIZE.
// Path: an accepted pixel passes stage 1 (RAM read), the window and job
// registers, then the sum, multiply and output registers.
// Throughput: one pixel per cycle while the receiver does not stall, except that
// a pixel producing k words (2 at a row end or on the last row, 4 at the last
// pixel) holds the input while the result generator emits them one word a cycle.
// The line buffers are one RAM (read at accept, written back when the
// pixel leaves stage 1); consecutive pixels always hit different columns,
// so no forwarding is needed.
// Reset (synchronous, active low) empties the pipeline, zeroes the
// position and sets the size to 32. Line buffers are not cleared.
// When the receiver stalls, the pipeline fills and then o_stall rises.
module box_blur_3x3_rgb_core import bb3_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_SIZE);

    function automatic logic [CW-1:0] size_last(input logic [SIZE_W-1:0] s);
        logic [31:0] v;
        v = 32'(s);
        if (v < 32'd2) v = 32'd2;
        if (v > 32'(MAX_SIZE)) v = 32'(MAX_SIZE);
        return CW'(v - 32'd1);
    endfunction

    // Position and size
    logic [CW-1:0] r_last, r_row, r_col;
    // Stage 1: RAM read in flight
    logic          r_s1v;
    t_px           r_s1_px;
    logic [CW-1:0] r_s1_row, r_s1_col;
    logic          r_s1_lr, r_s1_lc;
    // Window and job
    t_px           r_win [3][3];
    logic [KIND_N-1:0] r_jm;
    logic [CW-1:0] r_jrow, r_jcol;
    logic          r_jc2, r_jr2;
    // Sum stage
    logic              r_sv;
    logic [POS_W-1:0]  r_s_row, r_s_col;
    logic              r_s_last;
    t_div              r_s_div;
    logic [SUM_W-1:0]  r_s_sum [3];
    // Multiply stage
    logic              r_mv;
    logic [POS_W-1:0]  r_m_row, r_m_col;
    logic              r_m_last;
    logic [PROD_W-1:0] r_m_prod [3];
    // Output register
    logic              r_ov;
    t_out              r_o;

    logic accept, cfg_wr, s1_adv, emit, j_ready;
    logic o_free, m_free, s_free;
    logic [KIND_N-1:0] pick, rem;
    logic [KIND_N-1:0] n_jm;
    logic cm0, rm0;
    logic [CW-1:0] e_row, e_col;
    t_div e_div;
    logic [SUM_W-1:0] e_sum [3];
    logic [RECIP_W-1:0] recip;
    t_line rd_line, wr_line;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Back-pressure chain from the output register upward
    assign o_free  = !r_ov || !i_stall;
    assign m_free  = !r_mv || o_free;
    assign s_free  = !r_sv || m_free;
    assign pick    = r_jm & (~r_jm + KIND_N'(1));
    assign rem     = r_jm & ~pick;
    assign emit    = (r_jm != '0) && s_free;
    assign j_ready = (r_jm == '0) || (s_free && rem == '0);
    assign s1_adv  = r_s1v && j_ready;
    assign o_stall = r_s1v && !j_ready;
    assign accept  = i_valid && !o_stall;

    // Line buffer RAM: read at accept, write back when stage 1 moves on
    assign wr_line.older = rd_line.newer;
    assign wr_line.newer = r_s1_px;

    bb3_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_SIZE)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (wr_line),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_line)
    );

    // Advance position; a size write restarts the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= size_last(RESET_SIZE);
            r_row  <= '0;
            r_col  <= '0;
        end else if (cfg_wr) begin
            r_last <= size_last(i_cfg_data);
            r_row  <= '0;
            r_col  <= '0;
        end else if (accept) begin
            if (r_col == r_last) begin
                r_col <= '0;
                r_row <= (r_row == r_last) ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Job mask for the pixel leaving stage 1
    always_comb begin
        n_jm         = '0;
        n_jm[KIND_A] = (r_s1_row != '0) && (r_s1_col != '0);
        n_jm[KIND_B] = n_jm[KIND_A] && r_s1_lc;
        n_jm[KIND_C] = r_s1_lr && (r_s1_col != '0);
        n_jm[KIND_D] = n_jm[KIND_C] && r_s1_lc;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_jm  <= '0;
            r_sv  <= 1'b0;
            r_mv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1v <= 1'b1;
            end else if (s1_adv) begin
                r_s1v <= 1'b0;
            end
            if (s1_adv) begin
                r_jm <= n_jm;
            end else if (emit) begin
                r_jm <= rem;
            end
            if (s_free) begin
                r_sv <= emit;
            end
            if (m_free) begin
                r_mv <= r_sv;
            end
            if (o_free) begin
                r_ov <= r_mv;
            end
        end
    end

    // Select the next result's position and neighbourhood
    always_comb begin
        cm0   = (pick[KIND_A] || pick[KIND_C]) && r_jc2;
        rm0   = (pick[KIND_A] || pick[KIND_B]) && r_jr2;
        e_row = (pick[KIND_A] || pick[KIND_B]) ? r_jrow - CW'(1) : r_jrow;
        e_col = (pick[KIND_A] || pick[KIND_C]) ? r_jcol - CW'(1) : r_jcol;
        if (cm0 && rm0) begin
            e_div = DIV9;
        end else if (cm0 || rm0) begin
            e_div = DIV6;
        end else begin
            e_div = DIV4;
        end
        for (int k = 0; k < 3; k++) begin
            e_sum[k] = '0;
        end
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                if ((x != 0 || cm0) && (y != 0 || rm0)) begin
                    e_sum[0] = e_sum[0] + SUM_W'(r_win[x][y].red);
                    e_sum[1] = e_sum[1] + SUM_W'(r_win[x][y].green);
                    e_sum[2] = e_sum[2] + SUM_W'(r_win[x][y].blue);
                end
            end
        end
    end

    always_comb begin
        unique case (r_s_div)
            DIV9:    recip = RECIP9;
            DIV6:    recip = RECIP6;
            DIV4:    recip = RECIP4;
            default: recip = RECIP4;
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px.red   <= i_data.in_red;
            r_s1_px.green <= i_data.in_green;
            r_s1_px.blue  <= i_data.in_blue;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_lr       <= (r_row == r_last);
            r_s1_lc       <= (r_col == r_last);
        end
        if (s1_adv) begin
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2][0] <= rd_line.older;
            r_win[2][1] <= rd_line.newer;
            r_win[2][2] <= r_s1_px;
            r_jrow      <= r_s1_row;
            r_jcol      <= r_s1_col;
            r_jc2       <= (r_s1_col > CW'(1));
            r_jr2       <= (r_s1_row > CW'(1));
        end
        if (s_free) begin
            r_s_row  <= POS_W'(e_row);
            r_s_col  <= POS_W'(e_col);
            r_s_last <= (rem == '0);
            r_s_div  <= e_div;
            r_s_sum  <= e_sum;
        end
        if (m_free) begin
            r_m_row  <= r_s_row;
            r_m_col  <= r_s_col;
            r_m_last <= r_s_last;
            for (int k = 0; k < 3; k++) begin
                r_m_prod[k] <= PROD_W'(r_s_sum[k]) * PROD_W'(recip);
            end
        end
        if (o_free) begin
            r_o.out_row   <= r_m_row;
            r_o.out_col   <= r_m_col;
            r_o.out_red   <= r_m_prod[0][DIV_SHIFT +: CH_W];
            r_o.out_green <= r_m_prod[1][DIV_SHIFT +: CH_W];
            r_o.out_blue  <= r_m_prod[2][DIV_SHIFT +: CH_W];
            r_o.run_last  <= r_m_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_o;

endmodule

### rtl/bb3_chk.sv
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_core_macros.svh"
module bb3_chk import bb3_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    // A stalled output word stays put
    `BB3_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output word dropped under stall")
    `BB3_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_data), "output word changed under stall")
    // Reset empties the pipeline on both sides
    `BB3_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `BB3_ASSERT_RST(a_rst_in, i_clk, !i_rst_n |=> !o_stall, "input stalled after reset")

endmodule

bind box_blur_3x3_rgb_core bb3_chk u_bb3_chk (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bb3_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 16;

    // Running prediction of the 3x3 mean stream plus the words still owed
    class BlurScoreboard;
        t_out blur_expected[$];
        int   error_count;
        int   size_eff;
        int   row_pos;
        int   col_pos;
        t_px  older_row[MAX_SIZE_DEF];
        t_px  newer_row[MAX_SIZE_DEF];
        t_px  win[3][3];

        function new();
            error_count = 0;
            set_size(RESET_SIZE);
        endfunction

        function void set_size(logic [SIZE_W-1:0] v);
            size_eff = v;
            if (size_eff < 2) size_eff = 2;
            if (size_eff > MAX_SIZE_DEF) size_eff = MAX_SIZE_DEF;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void report(string what, int got, int want);
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
            error_count++;
        endfunction

        // Average window columns c0..2 and rows r0..2 into one word
        function t_out mean_word(int row, int col, int c0, int r0);
            int unsigned sr, sg, sb, cnt;
            t_out w;
            sr = 0; sg = 0; sb = 0; cnt = 0;
            for (int x = c0; x < 3; x++) begin
                for (int y = r0; y < 3; y++) begin
                    sr += win[x][y].red;
                    sg += win[x][y].green;
                    sb += win[x][y].blue;
                    cnt++;
                end
            end
            w.out_row   = row[POS_W-1:0];
            w.out_col   = col[POS_W-1:0];
            w.out_red   = 16'(sr / cnt);
            w.out_green = 16'(sg / cnt);
            w.out_blue  = 16'(sb / cnt);
            w.run_last  = 1'b0;
            return w;
        endfunction

        function void note_pixel(t_in p);
            t_out words[$];
            t_px  px;
            int   r, c, rtop, cl, n;
            n = size_eff;
            r = row_pos;
            c = col_pos;
            px.red   = p.in_red;
            px.green = p.in_green;
            px.blue  = p.in_blue;
            // Shift the window and load the new column
            win[0] = win[1];
            win[1] = win[2];
            win[2][0] = older_row[c];
            win[2][1] = newer_row[c];
            win[2][2] = px;
            older_row[c] = newer_row[c];
            newer_row[c] = px;
            cl = (c >= 2) ? 0 : 1;
            if (r >= 1 && c >= 1) begin
                rtop = (r >= 2) ? 0 : 1;
                words.push_back(mean_word(r - 1, c - 1, cl, rtop));
                if (c == n - 1) words.push_back(mean_word(r - 1, c, 1, rtop));
            end
            if (r == n - 1 && c >= 1) begin
                words.push_back(mean_word(r, c - 1, cl, 1));
                if (c == n - 1) words.push_back(mean_word(r, c, 1, 1));
            end
            if (words.size() > 0) words[words.size() - 1].run_last = 1'b1;
            foreach (words[i]) blur_expected.push_back(words[i]);
            // Advance the raster position, wrapping at image end
            c++;
            if (c >= n) begin
                c = 0;
                r++;
                if (r >= n) r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void check_word(t_out got);
            t_out want;
            if (blur_expected.size() == 0) begin
                report("unexpected word, row", got.out_row, -1);
                return;
            end
            want = blur_expected.pop_front();
            if (got.out_row !== want.out_row) report("row", got.out_row, want.out_row);
            if (got.out_col !== want.out_col) report("col", got.out_col, want.out_col);
            if (got.out_red !== want.out_red) report("red", got.out_red, want.out_red);
            if (got.out_green !== want.out_green)
                report("green", got.out_green, want.out_green);
            if (got.out_blue !== want.out_blue) report("blue", got.out_blue, want.out_blue);
            if (got.run_last !== want.run_last)
                report("run_last", got.run_last, want.run_last);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    t_in               i_data;
    logic              o_valid;
    logic              i_stall;
    t_out              o_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data;

    BlurScoreboard blur_sb;
    int            cycles;
    int            burst_left;
    bit            gappy;
    int            stall_mode;

    box_blur_3x3_rgb_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Receiver stall pattern: none, random, or long periodic holds
    always @(negedge i_clk) begin
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 9) < 3);
            end
            default: begin
                i_stall <= ((cycles % 23) < 7);
            end
        endcase
    end

    // Watch both channels and the run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) blur_sb.note_pixel(i_data);
            if (o_valid && !i_stall) blur_sb.check_word(o_data);
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_in random_pixel();
        t_in p;
        p.in_red   = 16'($urandom);
        p.in_green = 16'($urandom);
        p.in_blue  = 16'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            p.in_red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.in_green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            p.in_blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return p;
    endfunction

    // Offer one pixel word, in bursts with random gaps between them when gappy is set
    task automatic send_pixel(t_in p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gappy) begin
                repeat ($urandom_range(1, 5)) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= p;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Hold the sender until every owed word is back and the pipe is quiet
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (blur_sb.blur_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        blur_sb.set_size(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    initial begin
        t_in p;
        int  n;
        blur_sb     = new();
        cycles      = 0;
        burst_left  = 0;
        gappy       = 1'b0;
        stall_mode  = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest image: corners only, all four words on the last pixel
        write_size(11'd2);
        p = '0;
        send_pixel(p);
        p = '1;
        send_pixel(p);
        p = '{16'hFFFF, 16'h0000, 16'h8001};
        send_pixel(p);
        p = '{16'h0001, 16'hFFFE, 16'h7FFF};
        send_pixel(p);
        // Three by three: edges, corners and one interior, all channels at max
        write_size(11'd3);
        p = '1;
        repeat (9) send_pixel(p);
        // Sizes below the floor clamp to two
        write_size(11'd0);
        send_random(4);
        write_size(11'd1);
        send_random(4);

        // Reset size of 32, partly streamed, then cut by a new size
        gappy      = 1'b1;
        stall_mode = 1;
        write_size(11'd32);
        send_random(70);
        // Largest size: part of the first row only
        stall_mode = 0;
        gappy      = 1'b0;
        write_size(11'd1024);
        send_random(40);
        // Oversize clamps to the maximum; abandon partway
        write_size(11'h7FF);
        send_random(30);

        // Random full images of small sizes, with some cut short
        for (int k = 0; k < 5; k++) begin
            gappy      = $urandom_range(0, 2) != 0;
            stall_mode = $urandom_range(0, 2);
            n = $urandom_range(2, 5);
            write_size(SIZE_W'(n));
            if ($urandom_range(0, 4) == 0) send_random($urandom_range(1, n * n - 1));
            else send_random(n * n);
        end

        drain();
        if (blur_sb.error_count == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/box_blur_3x3_rgb_core.sv
rtl/bb3_chk.sv
dv/tb_top.sv
